@@ hw/rtl/tsoh_pkg.sv @@
`default_nettype none

package tsoh_pkg;

    // Beat kinds carried on s_tuser
    localparam logic KIND_TABLE_WRITE = 1'b0;
    localparam logic KIND_HASH_BYTE   = 1'b1;

    // One substituted byte on its way from the front to the back
    typedef struct packed {
        logic [7:0] mixed;
        logic       last;
    } tsoh_item_t;

    // Handshake of the queue towards either side
    typedef struct packed {
        logic       valid;
        tsoh_item_t item;
    } tsoh_slot_t;

endpackage

`default_nettype wire

@@ hw/rtl/tsoh_front.sv @@
`default_nettype none

module tsoh_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic              kind,
    input  wire logic [7:0]        table_index,
    input  wire logic [7:0]        table_value,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    output tsoh_pkg::tsoh_slot_t   push
);
    import tsoh_pkg::*;

    logic [7:0] table_mem [256];
    logic [7:0] rd_table_reg;
    logic [7:0] rd_byte_reg;
    logic       rd_last_reg;
    logic       rd_valid_reg;
    logic       rd_valid_next;

    // Table port: write on a load beat, registered read on a hash beat
    always_ff @(posedge aclk) begin
        if (accept && kind == KIND_TABLE_WRITE) begin
            table_mem[table_index] <= table_value;
        end
        if (accept && kind == KIND_HASH_BYTE) begin
            rd_table_reg <= table_mem[data_byte];
            rd_byte_reg  <= data_byte;
            rd_last_reg  <= last_byte;
        end
    end

    // Mark a hash byte as in flight for one cycle
    always_comb begin
        rd_valid_next = accept && kind == KIND_HASH_BYTE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd_valid_next;
        end
    end

    // Substitute and hand on to the queue
    always_comb begin
        push.valid      = rd_valid_reg;
        push.item.mixed = rd_byte_reg ^ rd_table_reg;
        push.item.last  = rd_last_reg;
    end

endmodule

`default_nettype wire

@@ hw/rtl/tsoh_queue.sv @@
`default_nettype none

module tsoh_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire tsoh_pkg::tsoh_slot_t   push,
    input  wire logic                   pop,
    output tsoh_pkg::tsoh_slot_t        head,
    output logic                        room
);
    import tsoh_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] RoomMax = CntW'(DEPTH - 2);

    tsoh_item_t      slots [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_pop;

    assign do_pop = pop && count_reg != '0;

    // Store pushed beats
    always_ff @(posedge aclk) begin
        if (push.valid) begin
            slots[wr_ptr_reg] <= push.item;
        end
    end

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push.valid, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Leave space for the beat in the table read stage as well as a new one
    assign room = count_reg <= RoomMax;

    // Present the oldest beat
    always_comb begin
        head.valid = count_reg != '0;
        head.item  = slots[rd_ptr_reg];
    end

endmodule

`default_nettype wire

@@ hw/rtl/tsoh_back.sv @@
`default_nettype none

module tsoh_back (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire tsoh_pkg::tsoh_slot_t   head,
    output logic                        pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [31:0]                 m_tdata
);
    import tsoh_pkg::*;

    localparam int MixAdd   = 10;
    localparam int MixXor   = 6;
    localparam int FinAdd1  = 3;
    localparam int FinXor   = 11;
    localparam int FinAdd2  = 15;

    logic [31:0] hash_reg, hash_next;
    logic [31:0] fin_hash_reg, fin_hash_next;
    logic        fin_valid_reg, fin_valid_next;
    logic [31:0] out_data_reg, out_data_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free, fin_move, fin_free;
    logic [31:0] mix_sum, mix_spread, mix_value;
    logic [31:0] av_a, av_b, av_c;

    // One round of the byte mix
    always_comb begin
        mix_sum    = hash_reg + {24'b0, head.item.mixed};
        mix_spread = mix_sum + (mix_sum << MixAdd);
        mix_value  = mix_spread ^ (mix_spread >> MixXor);
    end

    // Final avalanche of a completed message
    always_comb begin
        av_a = fin_hash_reg + (fin_hash_reg << FinAdd1);
        av_b = av_a ^ (av_a >> FinXor);
        av_c = av_b + (av_b << FinAdd2);
    end

    // Stall only a last byte whose finishing slot is still taken
    always_comb begin
        out_free = !out_valid_reg || m_tready;
        fin_move = fin_valid_reg && out_free;
        fin_free = !fin_valid_reg || fin_move;
        pop      = head.valid && (!head.item.last || fin_free);
    end

    always_comb begin
        hash_next      = hash_reg;
        fin_hash_next  = fin_hash_reg;
        fin_valid_next = fin_valid_reg && !fin_move;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (pop) begin
            if (head.item.last) begin
                hash_next      = '0;
                fin_hash_next  = mix_value;
                fin_valid_next = 1'b1;
            end else begin
                hash_next = mix_value;
            end
        end
        if (fin_move) begin
            out_data_next  = av_c;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg      <= '0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            hash_reg      <= hash_next;
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
        fin_hash_reg <= fin_hash_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/table_substituted_one_at_a_time_hash_unit.sv @@
// One-at-a-time byte hash with a loadable substitution table. A beat with
// s_tuser low writes table entry s_tdata[7:0] with s_tdata[15:8]; a beat with
// s_tuser high hashes byte s_tdata[23:16], first XORed with the table entry
// that the byte selects, and s_tlast closes the message: its beat yields one
// 32-bit hash on m_tdata and the running hash restarts at zero. Every table
// entry must be loaded before a byte reads it. The block takes one beat per
// clock while s_tready is high, loads and bytes alike, as set by the mix of
// the running hash; a hash is offered on m_tvalid once its last byte has
// passed the table read register, the queue, the mix and output registers.
// The queue between the table read and the mix absorbs stalls on m_tready,
// so s_tready drops only once the queue is close to full.
`default_nettype none

module table_substituted_one_at_a_time_hash_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // table_index, table_value, data_byte
    input  wire logic [0:0]  s_tuser,   // kind
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // hash_value
);
    import tsoh_pkg::*;

    tsoh_slot_t push, head;
    logic       pop;
    logic       room;
    logic       accept;

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    // Front: table load and substitution
    tsoh_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .kind        (s_tuser[0]),
        .table_index (s_tdata[7:0]),
        .table_value (s_tdata[15:8]),
        .data_byte   (s_tdata[23:16]),
        .last_byte   (s_tlast),
        .push        (push)
    );

    // Decouple the table read from the mix
    tsoh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .room    (room)
    );

    // Back: running mix, avalanche and output register
    tsoh_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
